// ===== sv/spq_pkg.sv =====
// Package for the sorted priority queue: sizes, operation and status codes,
// the cell link and control structs and the max helpers. No dependencies.
package spq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int POS_W = 6;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int VAL_W = 32;
  localparam int PRIO_W = 16;
  localparam int MAXV_W = VAL_W - 1;
  localparam int TREE_STAGES = ($clog2(CAPACITY) + 1) / 2;
  localparam int TREE_LEAVES = 4 ** TREE_STAGES;
  localparam int STG_W = $clog2(TREE_STAGES + 1);
  localparam logic [PRIO_W-1:0] PRIO_MAX = {PRIO_W{1'b1}};

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_RAISE,
    OP_LOWER
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_FULL,
    ST_NOPOS
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SETTLE,
    FSM_DELIVER
  } fsm_e;

  // Data handed between neighbouring cells
  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [PRIO_W-1:0] prio;
    logic              ge;
  } cell_link_t;

  // Broadcast to every cell
  typedef struct packed {
    logic              apply;
    op_e               op;
    logic [VAL_W-1:0]  value;
    logic [PRIO_W-1:0] prio;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
  } spq_ctrl_t;

  function automatic logic [MAXV_W-1:0] max2(input logic [MAXV_W-1:0] a,
                                             input logic [MAXV_W-1:0] b);
    max2 = (a > b) ? a : b;
  endfunction

  function automatic logic [MAXV_W-1:0] max4(input logic [MAXV_W-1:0] a,
                                             input logic [MAXV_W-1:0] b,
                                             input logic [MAXV_W-1:0] c,
                                             input logic [MAXV_W-1:0] d);
    max4 = max2(max2(a, b), max2(c, d));
  endfunction

endpackage

// ===== sv/spq_cell.sv =====
// One queue cell: holds a single (value, priority) entry and shifts it to or
// from its neighbours. Depends on spq_pkg.
module spq_cell (
  input  logic                      clk_i,
  input  logic [spq_pkg::IDX_W-1:0] cell_idx_i,
  input  spq_pkg::spq_ctrl_t        ctrl_i,
  input  spq_pkg::cell_link_t       left_i,
  input  spq_pkg::cell_link_t       right_i,
  output spq_pkg::cell_link_t       link_o,
  output logic                      keep_o,
  output logic [spq_pkg::MAXV_W-1:0] leaf_o
);
  import spq_pkg::*;

  logic [VAL_W-1:0]  value_q, value_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic              occupied;
  logic              ge;
  logic              at_or_after_pos;

  assign occupied = CMP_W'(cell_idx_i) < CMP_W'(ctrl_i.count);
  assign ge = occupied && (prio_q >= ctrl_i.prio);
  assign at_or_after_pos = CMP_W'(cell_idx_i) >= CMP_W'(ctrl_i.pos);

  assign link_o.value = value_q;
  assign link_o.prio  = prio_q;
  assign link_o.ge    = ge;
  assign keep_o = occupied && (prio_q > PRIO_W'(1));
  assign leaf_o = (occupied && !value_q[VAL_W-1]) ? value_q[MAXV_W-1:0] : '0;

  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    if (ctrl_i.apply) begin
      case (ctrl_i.op)
        OP_INSERT: begin
          // stay if this entry ranks at or above the new one
          if (!ge) begin
            if (left_i.ge) begin
              value_d = ctrl_i.value;
              prio_d  = ctrl_i.prio;
            end else begin
              value_d = left_i.value;
              prio_d  = left_i.prio;
            end
          end
        end
        OP_REMOVE: begin
          if (at_or_after_pos) begin
            value_d = right_i.value;
            prio_d  = right_i.prio;
          end
        end
        OP_RAISE: begin
          if (prio_q != PRIO_MAX) prio_d = prio_q + PRIO_W'(1);
        end
        OP_LOWER: begin
          if (prio_q > PRIO_W'(1)) prio_d = prio_q - PRIO_W'(1);
        end
        default: begin
          value_d = value_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

endmodule

// ===== sv/spq_max_tree.sv =====
// Registered 4:1 reduction tree that finds the largest non-negative value
// held in the cell row. Depends on spq_pkg.
module spq_max_tree (
  input  logic                                    clk_i,
  input  logic [spq_pkg::CAPACITY-1:0][spq_pkg::MAXV_W-1:0] leaves_i,
  output logic [spq_pkg::MAXV_W-1:0]              max_o
);
  import spq_pkg::*;

  logic [MAXV_W-1:0] padded [TREE_LEAVES];
  logic [MAXV_W-1:0] tree_q [TREE_STAGES][TREE_LEAVES];

  always_comb begin
    for (int k = 0; k < TREE_LEAVES; k++) begin
      padded[k] = '0;
    end
    for (int k = 0; k < CAPACITY; k++) begin
      padded[k] = leaves_i[k];
    end
  end

  for (genvar s = 0; s < TREE_STAGES; s++) begin : g_stage
    for (genvar i = 0; i < TREE_LEAVES; i++) begin : g_node
      if (i < (TREE_LEAVES >> (2 * (s + 1)))) begin : g_live
        if (s == 0) begin : g_first
          always_ff @(posedge clk_i) begin
            tree_q[s][i] <= max4(padded[4*i], padded[4*i+1],
                                 padded[4*i+2], padded[4*i+3]);
          end
        end else begin : g_next
          always_ff @(posedge clk_i) begin
            tree_q[s][i] <= max4(tree_q[s-1][4*i], tree_q[s-1][4*i+1],
                                 tree_q[s-1][4*i+2], tree_q[s-1][4*i+3]);
          end
        end
      end else begin : g_pad
        always_ff @(posedge clk_i) begin
          tree_q[s][i] <= '0;
        end
      end
    end
  end

  assign max_o = tree_q[TREE_STAGES-1][0];

endmodule

// ===== sv/sorted_priority_queue_core.sv =====
// Sorted priority queue of (value, priority) entries kept as a row of cells
// in descending priority order. Depends on spq_pkg, spq_cell, spq_max_tree.
//
// One transaction is taken at a time. The cell row applies insert, remove,
// raise or lower in the cycle of acceptance; the largest-value result then
// runs through the registered reduction tree, and the result is loaded into
// the output register once the tree has settled. The next transaction is
// taken only after that load, which waits while an unread result is stalled.
// A finished result waits in the output register while the next transaction
// is being worked on.
module sorted_priority_queue_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic signed [31:0] item_value_i,
  input  logic [15:0] item_priority_i,
  input  logic [5:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [6:0]  entry_count_o,
  output logic        queue_empty_o,
  output logic [15:0] head_priority_o,
  output logic [30:0] largest_value_o
);
  import spq_pkg::*;

  fsm_e              state_q, state_d;
  logic [STG_W-1:0]  stage_cnt_q, stage_cnt_d;
  logic [CNT_W-1:0]  count_q, count_d;
  status_e           status_q, status_d;
  logic              out_valid_q, out_valid_d;
  logic              load_out;
  logic [1:0]        out_status_q;
  logic [6:0]        out_count_q;
  logic              out_empty_q;
  logic [PRIO_W-1:0] out_head_q;
  logic [MAXV_W-1:0] out_max_q;

  logic              in_accept;
  op_e               op;
  logic              full;
  logic              pos_occupied;
  spq_ctrl_t         ctrl;
  cell_link_t        links [CAPACITY];
  logic [CAPACITY-1:0] keep;
  logic [CAPACITY-1:0] boundary;
  logic [IDX_W-1:0]  boundary_idx;
  logic [CAPACITY-1:0][MAXV_W-1:0] leaves;
  logic [MAXV_W-1:0] tree_max;
  cell_link_t        head_link;
  cell_link_t        tail_link;

  assign in_stall_o = (state_q != FSM_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign op = op_e'(operation_i);
  assign full = (count_q == CNT_W'(CAPACITY));
  assign pos_occupied = CMP_W'(position_i) < CMP_W'(count_q);

  always_comb begin
    ctrl.apply = in_accept && !((op == OP_INSERT) && full)
                 && !((op == OP_REMOVE) && !pos_occupied);
    ctrl.op    = op;
    ctrl.value = item_value_i;
    ctrl.prio  = item_priority_i;
    ctrl.pos   = position_i;
    ctrl.count = count_q;
  end

  // the head cell always sees a higher-ranked neighbour, the tail sees nothing
  assign head_link = '{value: '0, prio: '0, ge: 1'b1};
  assign tail_link = '{value: '0, prio: '0, ge: 1'b0};

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    spq_cell u_cell (
      .clk_i     (clk_i),
      .cell_idx_i(IDX_W'(k)),
      .ctrl_i    (ctrl),
      .left_i    ((k == 0) ? head_link : links[(k == 0) ? 0 : k - 1]),
      .right_i   ((k == CAPACITY - 1) ? tail_link
                                      : links[(k == CAPACITY - 1) ? k : k + 1]),
      .link_o    (links[k]),
      .keep_o    (keep[k]),
      .leaf_o    (leaves[k])
    );
  end

  spq_max_tree u_max_tree (
    .clk_i   (clk_i),
    .leaves_i(leaves),
    .max_o   (tree_max)
  );

  // surviving entries after a lower form a prefix: find its last cell
  always_comb begin
    boundary_idx = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (k == CAPACITY - 1) begin
        boundary[k] = keep[k];
      end else begin
        boundary[k] = keep[k] && !keep[k+1];
      end
      if (boundary[k]) boundary_idx = boundary_idx | IDX_W'(k);
    end
  end

  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    if (in_accept) begin
      status_d = ST_DONE;
      case (op)
        OP_INSERT: begin
          if (full) status_d = ST_FULL;
          else      count_d = count_q + CNT_W'(1);
        end
        OP_REMOVE: begin
          if (!pos_occupied) status_d = ST_NOPOS;
          else               count_d = count_q - CNT_W'(1);
        end
        OP_RAISE: begin
          count_d = count_q;
        end
        OP_LOWER: begin
          count_d = (|boundary) ? CNT_W'(boundary_idx) + CNT_W'(1) : '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    stage_cnt_d = stage_cnt_q;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      FSM_IDLE: begin
        if (in_accept) begin
          state_d     = FSM_SETTLE;
          stage_cnt_d = '0;
        end
      end
      FSM_SETTLE: begin
        // wait for the reduction tree to catch up with the cell row
        if (stage_cnt_q == STG_W'(TREE_STAGES - 1)) begin
          state_d = FSM_DELIVER;
        end else begin
          stage_cnt_d = stage_cnt_q + STG_W'(1);
        end
      end
      FSM_DELIVER: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      stage_cnt_q <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_cnt_q <= stage_cnt_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (load_out) begin
      out_status_q <= 2'(status_q);
      out_count_q  <= 7'(count_q);
      out_empty_q  <= (count_q == '0);
      out_head_q   <= (count_q == '0) ? '0 : links[0].prio;
      out_max_q    <= tree_max;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign entry_count_o   = out_count_q;
  assign queue_empty_o   = out_empty_q;
  assign head_priority_o = out_head_q;
  assign largest_value_o = out_max_q;

endmodule

// ===== tb/sorted_priority_queue_core_tb.sv =====
// Testbench for sorted_priority_queue_core: directed and random transactions
// checked against a sorted-store model in a small scoreboard class.
// Depends on spq_pkg and the core RTL.
`timescale 1ns / 1ps

module sorted_priority_queue_core_tb;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int DRAIN_CYCLES = 4 * (TREE_STAGES + 2);

  typedef struct packed {
    status_e           status;
    logic [CNT_W-1:0]  count;
    logic              empty;
    logic [PRIO_W-1:0] head;
    logic [MAXV_W-1:0] largest;
  } queue_result_t;

  class queue_scoreboard;
    logic [VAL_W-1:0]  vals[CAPACITY];
    logic [PRIO_W-1:0] prios[CAPACITY];
    int                held;
    int                errors;
    queue_result_t     expected_q[$];

    function new();
      held = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Apply one accepted transaction to the store and queue the result it implies
    function void note_input(op_e op, logic [VAL_W-1:0] value, logic [PRIO_W-1:0] prio,
                             logic [POS_W-1:0] pos);
      int            k;
      int            slot;
      int            keep;
      queue_result_t r;
      r.status = ST_DONE;
      case (op)
        OP_INSERT: begin
          if (held >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            slot = 0;
            // go behind every entry of equal or higher priority
            while (slot < held && prios[slot] >= prio) slot++;
            for (k = held; k > slot; k--) begin
              vals[k] = vals[k-1];
              prios[k] = prios[k-1];
            end
            vals[slot] = value;
            prios[slot] = prio;
            held++;
          end
        end
        OP_REMOVE: begin
          if (int'(pos) >= held) begin
            r.status = ST_NOPOS;
          end else begin
            for (k = pos; k + 1 < held; k++) begin
              vals[k] = vals[k+1];
              prios[k] = prios[k+1];
            end
            held--;
          end
        end
        OP_RAISE: begin
          for (k = 0; k < held; k++)
            if (prios[k] != PRIO_MAX) prios[k] = prios[k] + 1'b1;
        end
        default: begin
          keep = 0;
          for (k = 0; k < held; k++) begin
            if (prios[k] > 1) begin
              prios[k] = prios[k] - 1'b1;
              keep = k + 1;
            end
          end
          held = keep;
        end
      endcase
      r.count = held[CNT_W-1:0];
      r.empty = (held == 0);
      r.head = (held == 0) ? '0 : prios[0];
      r.largest = '0;
      for (k = 0; k < held; k++)
        if (!vals[k][VAL_W-1] && vals[k][MAXV_W-1:0] > r.largest)
          r.largest = vals[k][MAXV_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [CNT_W-1:0] count, logic empty,
                               logic [PRIO_W-1:0] head, logic [MAXV_W-1:0] largest);
      queue_result_t r;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no transaction outstanding, status %0d count %0d",
                 $time, status, count);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (status !== r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, r.status, status);
        errors++;
      end
      if (count !== r.count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, r.count, count);
        errors++;
      end
      if (empty !== r.empty) begin
        $display("%0t: queue_empty expected %0d actual %0d", $time, r.empty, empty);
        errors++;
      end
      if (head !== r.head) begin
        $display("%0t: head_priority expected %0d actual %0d", $time, r.head, head);
        errors++;
      end
      if (largest !== r.largest) begin
        $display("%0t: largest_value expected %0d actual %0d", $time, r.largest, largest);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  operation_i;
  logic signed [31:0] item_value_i;
  logic [15:0] item_priority_i;
  logic [5:0]  position_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic [6:0]  entry_count_o;
  logic        queue_empty_o;
  logic [15:0] head_priority_o;
  logic [30:0] largest_value_o;

  queue_scoreboard sb;
  bit              calm;
  int              cycles;

  sorted_priority_queue_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .item_value_i    (item_value_i),
    .item_priority_i (item_priority_i),
    .position_i      (position_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .entry_count_o   (entry_count_o),
    .queue_empty_o   (queue_empty_o),
    .head_priority_o (head_priority_o),
    .largest_value_o (largest_value_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL sorted_priority_queue_core");
      $finish;
    end
  end

  // Take results, stalling at random outside the calm stretch
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && !out_stall_i)
        sb.check_result(status_o, entry_count_o, queue_empty_o, head_priority_o,
                        largest_value_o);
      out_stall_i <= !calm && ($urandom_range(99) < 26);
    end
  end

  // Offer one transaction, idling at random first, and return once it is taken
  task automatic send_item(op_e op, logic [31:0] value, logic [15:0] prio, logic [5:0] pos);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    item_value_i <= value;
    item_priority_i <= prio;
    position_i <= pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(op, value, prio, pos);
  endtask

  initial begin
    int          n;
    int          i;
    int          len;
    int          mode;
    int          r;
    int          s;
    op_e         op;
    logic [31:0] v;
    logic [15:0] p;
    logic [5:0]  pos;

    sb = new();
    calm = 1'b0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    operation_i <= OP_INSERT;
    item_value_i <= '0;
    item_priority_i <= '0;
    position_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue: raise, lower and removes change nothing
    send_item(OP_RAISE, 32'h0, 16'h0, 6'd0);
    send_item(OP_LOWER, 32'h0, 16'h0, 6'd0);
    send_item(OP_REMOVE, 32'h0, 16'h0, 6'd0);
    send_item(OP_REMOVE, 32'h0, 16'h0, 6'd63);
    // field extremes, with ties at the top and bottom priorities
    send_item(OP_INSERT, 32'h7FFF_FFFF, 16'hFFFF, 6'd0);
    send_item(OP_INSERT, 32'h8000_0000, 16'h0000, 6'd0);
    send_item(OP_INSERT, 32'h0000_0000, 16'h0001, 6'd0);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 6'd0);
    send_item(OP_INSERT, 32'h0000_0005, 16'h0001, 6'd0);
    // head saturates at the top priority
    send_item(OP_RAISE, 32'h0, 16'h0, 6'd0);
    send_item(OP_REMOVE, 32'h0, 16'h0, 6'd0);
    send_item(OP_REMOVE, 32'h0, 16'h0, 6'd63);
    send_item(OP_REMOVE, 32'h0, 16'h0, 6'd4);
    send_item(OP_REMOVE, 32'h0, 16'h0, 6'd3);
    send_item(OP_LOWER, 32'h0, 16'h0, 6'd0);
    send_item(OP_LOWER, 32'h0, 16'h0, 6'd0);
    send_item(OP_LOWER, 32'h0, 16'h0, 6'd0);
    // negative values only: largest reads zero, and again once lowers drop the positives
    send_item(OP_INSERT, 32'hFFFF_FFFB, 16'h0003, 6'd0);
    send_item(OP_INSERT, 32'h0000_0001, 16'h0000, 6'd0);
    send_item(OP_INSERT, 32'h0000_0002, 16'h0000, 6'd0);
    send_item(OP_LOWER, 32'h0, 16'h0, 6'd0);
    send_item(OP_LOWER, 32'h0, 16'h0, 6'd0);
    send_item(OP_LOWER, 32'h0, 16'h0, 6'd0);
    send_item(OP_LOWER, 32'h0, 16'h0, 6'd0);

    // random episodes: fill to full, drain, mixed, and low-priority churn
    n = 0;
    while (n < RANDOM_ITEMS) begin
      mode = $urandom_range(3);
      len = (mode == 0) ? $urandom_range(120, 60) : $urandom_range(80, 20);
      for (i = 0; i < len; i++) begin
        calm = (n >= 600 && n < 900);
        r = $urandom_range(99);
        case (mode)
          0: op = (r < 85) ? OP_INSERT : (r < 92) ? OP_REMOVE : (r < 96) ? OP_RAISE : OP_LOWER;
          1: op = (r < 55) ? OP_REMOVE : (r < 75) ? OP_LOWER : (r < 85) ? OP_RAISE : OP_INSERT;
          2: op = op_e'($urandom_range(3));
          default:
            op = (r < 40) ? OP_INSERT : (r < 55) ? OP_REMOVE : (r < 75) ? OP_RAISE : OP_LOWER;
        endcase
        s = $urandom_range(9);
        if (mode == 3 || s >= 8) p = 16'($urandom_range(3));
        else if (s < 4) p = 16'($urandom_range(16'hFFFF));
        else if (s < 6) p = 16'($urandom_range(103, 100));
        else p = 16'($urandom_range(16'hFFFF, 16'hFFFC));
        s = $urandom_range(7);
        if (s < 5) begin
          v = $urandom;
        end else if (s == 5) begin
          case ($urandom_range(3))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h0000_0000;
            default: v = 32'hFFFF_FFFF;
          endcase
        end else begin
          v = $urandom_range(16) - 8;
        end
        if (sb.held > 0 && $urandom_range(9) < 7) pos = 6'($urandom_range(sb.held - 1));
        else pos = 6'($urandom_range(63));
        send_item(op, v, p, pos);
        n++;
      end
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS sorted_priority_queue_core");
    end else begin
      $display("FAIL sorted_priority_queue_core");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/spq_pkg.sv
sv/spq_cell.sv
sv/spq_max_tree.sv
sv/sorted_priority_queue_core.sv
tb/sorted_priority_queue_core_tb.sv
